/* rtl/ascii_decimal_to_fixed_parser_defines.svh */
// Assertion macros used by the parser top level.
`ifndef ASCII_DECIMAL_TO_FIXED_PARSER_DEFINES_SVH
`define ASCII_DECIMAL_TO_FIXED_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
// check gated off while reset is held
`define ADTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check that also covers the reset cycles
`define ADTF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ADTF_ASSERT(lbl, prop, msg)
`define ADTF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/adtf_pkg.sv */
// Types, constants and helper functions for the ASCII decimal parser.
package adtf_pkg;

    // number format
    localparam int INT_BITS        = 16;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int VAL_W           = 32;
    localparam int INT_W           = INT_BITS - 1;
    localparam int FACC_W          = 30;
    localparam int FDIG_W          = 4;
    localparam int CNT_W           = $clog2(FRAC_BITS + 1);

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // scan phase
    typedef enum logic [1:0] {
        PH_BLANK,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } t_phase;

    // top-level sequencer state
    typedef enum logic [0:0] {
        ST_SCAN,
        ST_DIV
    } t_state;

    // scanner results handed to the sequencer at the terminating byte
    typedef struct packed {
        logic                negative;
        logic [INT_W-1:0]    int_acc;
        logic                int_ovf;
        logic [FACC_W-1:0]   frac_acc;
        logic [FDIG_W-1:0]   frac_digits;
        logic                fmt_ok;
    } t_snap;

    // 10^n for the fraction divisor
    function automatic logic [FACC_W-1:0] pow10(input logic [FDIG_W-1:0] n);
        logic [FACC_W-1:0] r;
        case (n)
            4'd0:    r = FACC_W'(1);
            4'd1:    r = FACC_W'(10);
            4'd2:    r = FACC_W'(100);
            4'd3:    r = FACC_W'(1000);
            4'd4:    r = FACC_W'(10000);
            4'd5:    r = FACC_W'(100000);
            4'd6:    r = FACC_W'(1000000);
            4'd7:    r = FACC_W'(10000000);
            4'd8:    r = FACC_W'(100000000);
            4'd9:    r = FACC_W'(1000000000);
            default: r = FACC_W'(1);
        endcase
        return r;
    endfunction

endpackage

/* rtl/adtf_scan.sv */
// Character scanner: blank skip, sign, integer and fraction accumulation, format check.
module adtf_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,      // accepted byte
    input  logic [7:0]          i_ch,
    output adtf_pkg::t_snap     o_snap
);

    adtf_pkg::t_phase r_phase, n_phase;
    logic                            r_neg, n_neg;
    logic [adtf_pkg::INT_W-1:0]      r_int, n_int;
    logic                            r_ovf, n_ovf;
    logic [adtf_pkg::FACC_W-1:0]     r_frac, n_frac;
    logic [adtf_pkg::FDIG_W-1:0]     r_fdig, n_fdig;
    logic [1:0]                      r_plus, n_plus;
    logic [1:0]                      r_minus, n_minus;
    logic [1:0]                      r_point, n_point;
    logic                            r_bad, n_bad;

    logic                            is_digit, is_blank, is_sign;
    logic                            is_term;
    logic [3:0]                      digit;
    logic [adtf_pkg::INT_W+3:0]      int_wide;
    logic                            int_sat;
    logic [adtf_pkg::FACC_W-1:0]     frac_next;
    logic                            take_int, take_frac;

    // character classes
    always_comb begin
        is_digit  = (i_ch >= adtf_pkg::CH_0) && (i_ch <= adtf_pkg::CH_9);
        is_blank  = (i_ch == adtf_pkg::CH_SPACE) ||
                    ((i_ch >= adtf_pkg::CH_TAB) && (i_ch <= adtf_pkg::CH_CR));
        is_sign   = (i_ch == adtf_pkg::CH_PLUS) || (i_ch == adtf_pkg::CH_MINUS);
        is_term   = (i_ch == adtf_pkg::CH_NUL);
        digit     = 4'(i_ch - adtf_pkg::CH_0);
    end

    // phase transitions
    always_comb begin
        n_phase = r_phase;
        if (i_en) begin
            if (is_term) begin
                n_phase = adtf_pkg::PH_BLANK;
            end else begin
                unique case (r_phase)
                    adtf_pkg::PH_BLANK: begin
                        if (is_blank) n_phase = adtf_pkg::PH_BLANK;
                        else if (is_sign || is_digit) n_phase = adtf_pkg::PH_INT;
                        else if (i_ch == adtf_pkg::CH_POINT) n_phase = adtf_pkg::PH_FRAC;
                        else n_phase = adtf_pkg::PH_DONE;
                    end
                    adtf_pkg::PH_INT: begin
                        if (is_digit) n_phase = adtf_pkg::PH_INT;
                        else if (i_ch == adtf_pkg::CH_POINT) n_phase = adtf_pkg::PH_FRAC;
                        else n_phase = adtf_pkg::PH_DONE;
                    end
                    adtf_pkg::PH_FRAC: begin
                        if (!is_digit) n_phase = adtf_pkg::PH_DONE;
                    end
                    default: n_phase = adtf_pkg::PH_DONE;
                endcase
            end
        end
    end

    // digit accumulation: x*10 + d as two shifts and two adds
    always_comb begin
        int_wide  = ({4'b0, r_int} << 3) + ({4'b0, r_int} << 1) +
                    (adtf_pkg::INT_W + 4)'(digit);
        int_sat   = int_wide > {4'b0, {adtf_pkg::INT_W{1'b1}}};
        frac_next = (r_frac << 3) + (r_frac << 1) + adtf_pkg::FACC_W'(digit);
        take_int  = is_digit && ((r_phase == adtf_pkg::PH_BLANK) ||
                                 (r_phase == adtf_pkg::PH_INT));
        take_frac = is_digit && (r_phase == adtf_pkg::PH_FRAC) &&
                    (r_fdig < adtf_pkg::FDIG_W'(adtf_pkg::MAX_FRAC_DIGITS));
    end

    // datapath and format counters
    always_comb begin
        n_neg   = r_neg;
        n_int   = r_int;
        n_ovf   = r_ovf;
        n_frac  = r_frac;
        n_fdig  = r_fdig;
        n_plus  = r_plus;
        n_minus = r_minus;
        n_point = r_point;
        n_bad   = r_bad;
        if (i_en) begin
            if (is_term) begin
                n_neg   = 1'b0;
                n_int   = '0;
                n_ovf   = 1'b0;
                n_frac  = '0;
                n_fdig  = '0;
                n_plus  = '0;
                n_minus = '0;
                n_point = '0;
                n_bad   = 1'b0;
            end else begin
                if (i_ch == adtf_pkg::CH_PLUS) begin
                    if (r_plus != 2'd2) n_plus = r_plus + 2'd1;
                end else if (i_ch == adtf_pkg::CH_MINUS) begin
                    if (r_minus != 2'd2) n_minus = r_minus + 2'd1;
                end else if (i_ch == adtf_pkg::CH_POINT) begin
                    if (r_point != 2'd2) n_point = r_point + 2'd1;
                end else if (!is_digit) begin
                    n_bad = 1'b1;
                end
                if (is_sign && (r_phase == adtf_pkg::PH_BLANK)) begin
                    n_neg = (i_ch == adtf_pkg::CH_MINUS);
                end
                if (take_int) begin
                    if (int_sat) begin
                        n_int = {adtf_pkg::INT_W{1'b1}};
                        n_ovf = 1'b1;
                    end else begin
                        n_int = int_wide[adtf_pkg::INT_W-1:0];
                    end
                end
                if (take_frac) begin
                    n_frac = frac_next;
                    n_fdig = r_fdig + adtf_pkg::FDIG_W'(1);
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= adtf_pkg::PH_BLANK;
            r_neg   <= 1'b0;
            r_int   <= '0;
            r_ovf   <= 1'b0;
            r_frac  <= '0;
            r_fdig  <= '0;
            r_plus  <= '0;
            r_minus <= '0;
            r_point <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_int   <= n_int;
            r_ovf   <= n_ovf;
            r_frac  <= n_frac;
            r_fdig  <= n_fdig;
            r_plus  <= n_plus;
            r_minus <= n_minus;
            r_point <= n_point;
            r_bad   <= n_bad;
        end
    end

    // snapshot for the sequencer
    always_comb begin
        o_snap.negative    = r_neg;
        o_snap.int_acc     = r_int;
        o_snap.int_ovf     = r_ovf;
        o_snap.frac_acc    = r_frac;
        o_snap.frac_digits = r_fdig;
        o_snap.fmt_ok      = !r_bad && (r_point <= 2'd1) && (r_plus <= 2'd1) &&
                             (r_minus <= 2'd1) && !((r_plus == 2'd1) && (r_minus == 2'd1));
    end

endmodule

/* rtl/adtf_div.sv */
// Restoring divider, one quotient bit per cycle: frac * 2^FRAC_BITS / 10^digits.
module adtf_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [adtf_pkg::FACC_W-1:0]       i_frac,
    input  logic [adtf_pkg::FDIG_W-1:0]       i_digits,
    output logic                              o_busy,
    output logic [adtf_pkg::FRAC_BITS-1:0]    o_quot
);

    logic                              r_busy, n_busy;
    logic [adtf_pkg::CNT_W-1:0]        r_cnt, n_cnt;
    logic [adtf_pkg::FACC_W-1:0]       r_rem, n_rem;
    logic [adtf_pkg::FACC_W-1:0]       r_div, n_div;
    logic [adtf_pkg::FRAC_BITS-1:0]    r_quot, n_quot;

    logic [adtf_pkg::FACC_W:0]         trial;
    logic                              ge;

    // one shift-compare-subtract step; remainder stays below the divisor
    always_comb begin
        trial = {r_rem, 1'b0};
        ge    = trial >= {1'b0, r_div};
    end

    // step control
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = adtf_pkg::CNT_W'(adtf_pkg::FRAC_BITS);
            n_rem  = i_frac;
            n_div  = adtf_pkg::pow10(i_digits);
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = ge ? adtf_pkg::FACC_W'(trial - {1'b0, r_div})
                        : trial[adtf_pkg::FACC_W-1:0];
            n_quot = {r_quot[adtf_pkg::FRAC_BITS-2:0], ge};
            n_cnt  = r_cnt - adtf_pkg::CNT_W'(1);
            n_busy = (r_cnt != adtf_pkg::CNT_W'(1));
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

/* rtl/ascii_decimal_to_fixed_parser.sv */
// Top level: ASCII decimal string to signed Q16.16 parser.
// Non-zero bytes: one transfer per cycle while scanning, no result.
// Zero byte: result valid after its transfer, 16 divider steps and one output load that
// waits for the output to free; input not ready from that transfer until the load.
// A waiting result does not stop byte transfers; the next zero byte holds the input until
// the output frees. Synchronous active-low reset clears the scan state and output valid.
`include "ascii_decimal_to_fixed_parser_defines.svh"
module ascii_decimal_to_fixed_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] value
    output logic [1:0]  o_m_axis_tuser    // [0] valid_res, [1] overflow
);

    adtf_pkg::t_state                  r_state, n_state;
    adtf_pkg::t_snap                   snap;

    logic                              in_xfer;
    logic                              term_xfer;
    logic                              div_start;
    logic                              div_busy;
    logic [adtf_pkg::FRAC_BITS-1:0]    div_quot;
    logic                              out_free;
    logic                              out_load;

    logic                              r_neg;
    logic [adtf_pkg::INT_W-1:0]        r_int;
    logic                              r_ovf;
    logic                              r_ok;

    logic                              r_m_tvalid;
    logic [adtf_pkg::VAL_W-1:0]        r_m_value;
    logic [1:0]                        r_m_user;
    logic [adtf_pkg::VAL_W-1:0]        mag;

    adtf_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (in_xfer),
        .i_ch    (i_s_axis_tdata),
        .o_snap  (snap)
    );

    adtf_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_frac   (snap.frac_acc),
        .i_digits (snap.frac_digits),
        .o_busy   (div_busy),
        .o_quot   (div_quot)
    );

    assign in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign term_xfer = in_xfer && (i_s_axis_tdata == adtf_pkg::CH_NUL);
    assign out_free  = !r_m_tvalid || i_m_axis_tready;

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            adtf_pkg::ST_SCAN: begin
                if (term_xfer) n_state = adtf_pkg::ST_DIV;
            end
            adtf_pkg::ST_DIV: begin
                if (!div_busy && out_free) n_state = adtf_pkg::ST_SCAN;
            end
            default: n_state = adtf_pkg::ST_SCAN;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            adtf_pkg::ST_SCAN: begin
                o_s_axis_tready = 1'b1;
                div_start       = term_xfer;
            end
            adtf_pkg::ST_DIV: begin
                out_load = !div_busy && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= adtf_pkg::ST_SCAN;
        end else begin
            r_state <= n_state;
        end
    end

    // hold integer part and flags while the fraction is divided
    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_neg <= snap.negative;
            r_int <= snap.int_acc;
            r_ovf <= snap.int_ovf;
            r_ok  <= snap.fmt_ok;
        end
    end

    // integer and fraction bits do not overlap, so the magnitude is a concatenation
    assign mag = adtf_pkg::VAL_W'({r_int, div_quot});

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_value <= r_neg ? (adtf_pkg::VAL_W'(0) - mag) : mag;
            r_m_user  <= {r_ovf, r_ok};
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_value;
    assign o_m_axis_tuser  = r_m_user;

    `ADTF_ASSERT(a_no_xfer_while_div, !(o_s_axis_tready && div_busy), "byte taken during divide")
    `ADTF_ASSERT(a_term_starts_div, term_xfer |=> div_busy, "divide not started")
    `ADTF_ASSERT(a_load_from_div, $rose(o_m_axis_tvalid) |-> $past(r_state == adtf_pkg::ST_DIV), "stray result")
    `ADTF_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")

endmodule
